[design/ppt_pkg.sv]
// Shared types, codes, constants and tables of the pure pursuit path tracker.
`timescale 1ns / 1ps

package ppt_pkg;

   localparam int PPT_MAX_POINTS = 256;

   // Squared distance in Q26.24 below which the final point counts as reached.
   localparam logic [49:0] GOAL_DIST2_MAX = 50'd167772;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [63:0] KAPPA_SAT = 64'd1099511627776;
   localparam logic [63:0] SLOW_THRESHOLD = 64'd268435456;

   localparam logic [1:0] ST_TRACKING  = 2'd0;
   localparam logic [1:0] ST_GOAL      = 2'd1;
   localparam logic [1:0] ST_NOT_READY = 2'd2;

   localparam logic [2:0] REG_ENABLE    = 3'd0;
   localparam logic [2:0] REG_LA_TIME   = 3'd1;
   localparam logic [2:0] REG_MIN_LA    = 3'd2;
   localparam logic [2:0] REG_MAX_LA    = 3'd3;
   localparam logic [2:0] REG_SPEED_LIM = 3'd4;
   localparam logic [2:0] REG_TURN_LIM  = 3'd5;
   localparam logic [2:0] REG_RADIUS    = 3'd6;

   typedef struct packed {
      logic               req_type;
      logic               first_point;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [15:0]        heading;
      logic signed [15:0] current_speed;
   } ppt_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] linear_speed;
      logic signed [15:0] angular_speed;
   } ppt_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_C_RD,
      S_C_MX,
      S_C_MY,
      S_C_CMP,
      S_GOAL,
      S_LA,
      S_W_RD0,
      S_W_LD0,
      S_W_RD1,
      S_W_LD1,
      S_W_MY,
      S_W_SUM,
      S_W_SQ,
      S_W_ACC,
      S_I_X,
      S_I_Y0,
      S_I_XD,
      S_I_YD,
      S_ROT,
      S_R_IT,
      S_R_M1,
      S_R_M2,
      S_R_Y,
      S_K_DIV,
      S_K_WAIT,
      S_S_SLOW,
      S_S_CMP,
      S_S_WAIT,
      S_O_MUL,
      S_O_CLAMP,
      S_FINISH
   } ppt_state_type;

   // Arctangent of 2^-i in units of 65536 per turn.
   function automatic logic [13:0] cordic_atan(input logic [3:0] i);
      logic [13:0] r;
      unique case (i)
         4'd0:  r = 14'd8192;
         4'd1:  r = 14'd4836;
         4'd2:  r = 14'd2555;
         4'd3:  r = 14'd1297;
         4'd4:  r = 14'd651;
         4'd5:  r = 14'd326;
         4'd6:  r = 14'd163;
         4'd7:  r = 14'd81;
         4'd8:  r = 14'd41;
         4'd9:  r = 14'd20;
         4'd10: r = 14'd10;
         4'd11: r = 14'd5;
         4'd12: r = 14'd3;
         4'd13: r = 14'd1;
         4'd14: r = 14'd1;
         default: r = 14'd0;
      endcase
      return r;
   endfunction

endpackage

[design/pure_pursuit_path_tracker.sv]
// Pure pursuit path tracker: a load stores one path point. A query runs a closest point
// search over every stored point, walks path segments with a 25 step square root for
// each, and then uses up to four divisions (two to interpolate the lookahead point, one
// for the curvature and one for the slowdown) and one 16 step CORDIC. All work goes
// through one registered multiplier, one radix-2 divider and one square root step
// under a single sequencer, and the path table is a memory with one write port and a
// registered read.
// The block takes no new transaction until the result of a query has moved into the
// output register, so a finished query waits while an earlier result is still held.
`timescale 1ns / 1ps

module pure_pursuit_path_tracker
   import ppt_pkg::*;
#(
   parameter int MAX_POINTS = PPT_MAX_POINTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ppt_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ppt_rsp_type rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   // Configuration registers.
   logic        enable_ff;
   logic [15:0] la_time_ff;
   logic [22:0] min_la_ff;
   logic [22:0] max_la_ff;
   logic [14:0] vmax_ff;
   logic [14:0] wlim_ff;
   logic [22:0] radius_ff;

   ppt_state_type state_ff, state_in;

   logic [47:0]        mem [MAX_POINTS];
   logic [47:0]        rd_ff;
   logic [AW-1:0]      rd_addr;
   logic [CW-1:0]      count_ff;

   logic signed [23:0] rx_ff, ry_ff;
   logic [15:0]        heading_ff;
   logic signed [15:0] speed_ff;
   logic [AW-1:0]      idx_ff, closest_ff;
   logic [49:0]        best_ff;
   logic signed [23:0] x0_ff, y0_ff, x1_ff, y1_ff, px_ff, py_ff;
   logic signed [24:0] dy_ff;
   logic signed [69:0] hold_ff;
   logic [22:0]        l_ff;
   logic [26:0]        acc_ff;

   logic signed [42:0] mul_a;
   logic signed [26:0] mul_b;
   logic signed [69:0] mul_ff;

   logic [49:0]        sq_val_ff;
   logic [27:0]        sq_rem_ff;
   logic [24:0]        sq_root_ff;
   logic [4:0]         sq_cnt_ff;

   logic signed [33:0] cx_ff, cy_ff;
   logic signed [16:0] cz_ff;
   logic               cneg_ff;
   logic [3:0]         citer_ff;

   logic signed [27:0] yr_ff;
   logic signed [41:0] kappa_ff;
   logic [14:0]        v_ff;

   logic               div_start;
   logic [63:0]        div_num, div_den;
   logic               div_neg;
   logic [64:0]        dv_rem_ff;
   logic [63:0]        dv_quo_ff, dv_den_ff;
   logic [6:0]         dv_cnt_ff;
   logic               dv_busy_ff, dv_neg_ff;

   ppt_rsp_type        cmd_ff;
   ppt_rsp_type        rsp_ff;
   logic               rsp_valid_ff;

   // Helper values.
   logic signed [23:0] rd_x, rd_y;
   logic signed [24:0] cdx, wdx, wdy, sdx, sdy;
   logic [49:0]        sum50;
   logic [CW:0]        idx_ext, cnt_ext, closest_ext;
   logic               last_pt;
   logic signed [69:0] la_raw, la_clip;
   logic [26:0]        acc_new;
   logic [22:0]        num;
   logic signed [64:0] dq;
   logic signed [24:0] ix_new, iy_new;
   logic signed [33:0] c_val, s_val;
   logic signed [33:0] sh_x, sh_y;
   logic signed [16:0] atan_v;
   logic signed [69:0] yr_full;
   logic [27:0]        yr_abs;
   logic [63:0]        ksat;
   logic [41:0]        kabs42;
   logic signed [69:0] om_raw;
   logic signed [69:0] lim70;
   logic signed [15:0] om_clip;
   logic [27:0]        sq_rem_t;
   logic [26:0]        sq_trial;
   logic [64:0]        dv_sh;
   logic               dv_ge;
   logic [CW-1:0]      load_base;
   logic               cfg_write;

   assign rd_x = rd_ff[47:24];
   assign rd_y = rd_ff[23:0];
   assign cdx = 25'(rx_ff) - 25'(rd_x);
   assign wdx = 25'(rd_x) - 25'(x0_ff);
   assign wdy = 25'(rd_y) - 25'(y0_ff);
   assign sdx = 25'(x1_ff) - 25'(x0_ff);
   assign sdy = 25'(y1_ff) - 25'(y0_ff);
   assign sum50 = hold_ff[49:0] + mul_ff[49:0];
   assign idx_ext = (CW+1)'(idx_ff);
   assign cnt_ext = (CW+1)'(count_ff);
   assign closest_ext = (CW+1)'(closest_ff);
   assign last_pt = (idx_ext + (CW+1)'(1)) == cnt_ext;
   assign la_raw = mul_ff >>> 12;
   assign la_clip = (la_raw > signed'(70'(max_la_ff))) ? signed'(70'(max_la_ff)) : la_raw;
   assign acc_new = acc_ff + 27'(sq_root_ff);
   assign num = l_ff - acc_ff[22:0];
   assign dq = dv_neg_ff ? -signed'({1'b0, dv_quo_ff}) : signed'({1'b0, dv_quo_ff});
   assign ix_new = 25'(x0_ff) + dq[24:0];
   assign iy_new = 25'(y0_ff) + dq[24:0];
   assign c_val = cneg_ff ? -cx_ff : cx_ff;
   assign s_val = cneg_ff ? -cy_ff : cy_ff;
   assign sh_x = cx_ff >>> citer_ff;
   assign sh_y = cy_ff >>> citer_ff;
   assign atan_v = 17'(cordic_atan(citer_ff));
   assign yr_full = (hold_ff - mul_ff) >>> 30;
   assign yr_abs = yr_ff[27] ? 28'(-yr_ff) : 28'(yr_ff);
   assign ksat = (dv_quo_ff > KAPPA_SAT) ? KAPPA_SAT : dv_quo_ff;
   assign kabs42 = kappa_ff[41] ? 42'(-kappa_ff) : 42'(kappa_ff);
   assign om_raw = mul_ff >>> 16;
   assign lim70 = signed'(70'(wlim_ff));
   assign om_clip = (om_raw > lim70) ? 16'(lim70) :
                    (om_raw < -lim70) ? 16'(-lim70) : om_raw[15:0];
   assign sq_rem_t = {sq_rem_ff[25:0], sq_val_ff[49:48]};
   assign sq_trial = {sq_root_ff, 2'b01};
   assign dv_sh = {dv_rem_ff[63:0], dv_quo_ff[63]};
   assign dv_ge = dv_sh >= {1'b0, dv_den_ff};
   assign load_base = req_data.first_point ? '0 : count_ff;
   assign cfg_write = psel && penable && pwrite;

   // Configuration port.
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         la_time_ff <= 16'd4096;
         min_la_ff  <= 23'd1229;
         max_la_ff  <= 23'd6144;
         vmax_ff    <= 15'd2048;
         wlim_ff    <= 15'd4096;
         radius_ff  <= 23'd4096;
      end else if (cfg_write) begin
         unique case (paddr[4:2])
            REG_ENABLE:    enable_ff  <= pwdata[0];
            REG_LA_TIME:   la_time_ff <= pwdata[15:0];
            REG_MIN_LA:    min_la_ff  <= pwdata[22:0];
            REG_MAX_LA:    max_la_ff  <= pwdata[22:0];
            REG_SPEED_LIM: vmax_ff    <= pwdata[14:0];
            REG_TURN_LIM:  wlim_ff    <= pwdata[14:0];
            REG_RADIUS:    radius_ff  <= pwdata[22:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_ENABLE:    prdata = 32'(enable_ff);
         REG_LA_TIME:   prdata = 32'(la_time_ff);
         REG_MIN_LA:    prdata = 32'(min_la_ff);
         REG_MAX_LA:    prdata = 32'(max_la_ff);
         REG_SPEED_LIM: prdata = 32'(vmax_ff);
         REG_TURN_LIM:  prdata = 32'(wlim_ff);
         REG_RADIUS:    prdata = 32'(radius_ff);
         default:       prdata = '0;
      endcase
   end

   // Path table.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid && !req_data.req_type
          && load_base < CW'(MAX_POINTS)) begin
         mem[load_base[AW-1:0]] <= {req_data.pos_x, req_data.pos_y};
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (state_ff == S_IDLE && req_valid && !req_data.req_type
                   && load_base < CW'(MAX_POINTS)) begin
         count_ff <= load_base + CW'(1);
      end
   end

   // Sequencer: next state and the controls of the shared units.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rd_addr   = idx_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      div_neg   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_data.req_type) begin
               if (!enable_ff || count_ff == '0) state_in = S_FINISH;
               else state_in = S_C_RD;
            end
         end
         S_C_RD: state_in = S_C_MX;
         S_C_MX: begin
            mul_a = 43'(cdx);
            mul_b = 27'(cdx);
            state_in = S_C_MY;
         end
         S_C_MY: begin
            mul_a = 43'(dy_ff);
            mul_b = 27'(dy_ff);
            state_in = S_C_CMP;
         end
         S_C_CMP: state_in = last_pt ? S_GOAL : S_C_RD;
         S_GOAL: begin
            mul_a = 43'(speed_ff);
            mul_b = 27'(la_time_ff);
            if (closest_ext + (CW+1)'(1) == cnt_ext && best_ff <= GOAL_DIST2_MAX)
               state_in = S_FINISH;
            else
               state_in = S_LA;
         end
         S_LA: begin
            rd_addr = closest_ff;
            state_in = S_W_LD0;
         end
         S_W_RD0: state_in = S_W_LD0;
         S_W_LD0: begin
            rd_addr = AW'(idx_ext + (CW+1)'(1));
            state_in = last_pt ? S_ROT : S_W_LD1;
         end
         S_W_RD1: begin
            rd_addr = AW'(idx_ext + (CW+1)'(1));
            state_in = S_W_LD1;
         end
         S_W_LD1: begin
            mul_a = 43'(wdx);
            mul_b = 27'(wdx);
            state_in = S_W_MY;
         end
         S_W_MY: begin
            mul_a = 43'(dy_ff);
            mul_b = 27'(dy_ff);
            state_in = S_W_SUM;
         end
         S_W_SUM: state_in = S_W_SQ;
         S_W_SQ: if (sq_cnt_ff == '0) state_in = S_W_ACC;
         S_W_ACC: begin
            mul_a = 43'(sdx);
            mul_b = 27'(num);
            if (acc_new >= 27'(l_ff)) begin
               state_in = (sq_root_ff == '0) ? S_ROT : S_I_X;
            end else if (idx_ext + (CW+1)'(2) >= cnt_ext) begin
               state_in = S_ROT;
            end else begin
               state_in = S_W_RD1;
            end
         end
         S_I_X: begin
            mul_a = 43'(sdy);
            mul_b = 27'(num);
            div_start = 1'b1;
            div_neg = mul_ff[69];
            div_num = mul_ff[69] ? 64'(-mul_ff) : 64'(mul_ff);
            div_den = 64'(sq_root_ff);
            state_in = S_I_Y0;
         end
         S_I_Y0: state_in = S_I_XD;
         S_I_XD: begin
            if (!dv_busy_ff) begin
               div_start = 1'b1;
               div_neg = hold_ff[69];
               div_num = hold_ff[69] ? 64'(-hold_ff) : 64'(hold_ff);
               div_den = 64'(sq_root_ff);
               state_in = S_I_YD;
            end
         end
         S_I_YD: if (!dv_busy_ff) state_in = S_ROT;
         S_ROT: state_in = S_R_IT;
         S_R_IT: if (citer_ff == 4'd15) state_in = S_R_M1;
         S_R_M1: begin
            mul_a = 43'(c_val);
            mul_b = 27'(25'(py_ff) - 25'(ry_ff));
            state_in = S_R_M2;
         end
         S_R_M2: begin
            mul_a = 43'(s_val);
            mul_b = 27'(25'(px_ff) - 25'(rx_ff));
            state_in = S_R_Y;
         end
         S_R_Y: begin
            mul_a = 43'(l_ff);
            mul_b = 27'(l_ff);
            state_in = S_K_DIV;
         end
         S_K_DIV: begin
            if (l_ff == '0) begin
               state_in = S_S_SLOW;
            end else begin
               div_start = 1'b1;
               div_neg = yr_ff[27];
               div_num = 64'(yr_abs) << 29;
               div_den = 64'(mul_ff[45:0]);
               state_in = S_K_WAIT;
            end
         end
         S_K_WAIT: if (!dv_busy_ff) state_in = S_S_SLOW;
         S_S_SLOW: begin
            mul_a = 43'(kabs42[40:0]);
            mul_b = 27'(radius_ff);
            state_in = S_S_CMP;
         end
         S_S_CMP: begin
            if (mul_ff[63:0] > SLOW_THRESHOLD) begin
               div_start = 1'b1;
               div_num = 64'(vmax_ff) << 28;
               div_den = mul_ff[63:0];
               state_in = S_S_WAIT;
            end else begin
               state_in = S_O_MUL;
            end
         end
         S_S_WAIT: if (!dv_busy_ff) state_in = S_O_MUL;
         S_O_MUL: begin
            mul_a = 43'(kappa_ff);
            mul_b = 27'(v_ff);
            state_in = S_O_CLAMP;
         end
         S_O_CLAMP: state_in = S_FINISH;
         S_FINISH: if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // Datapath registers of the query.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            rx_ff      <= req_data.pos_x;
            ry_ff      <= req_data.pos_y;
            heading_ff <= req_data.heading;
            speed_ff   <= req_data.current_speed;
            idx_ff     <= '0;
            cmd_ff     <= '{status: ST_NOT_READY, linear_speed: '0, angular_speed: '0};
         end
         S_C_MX: dy_ff <= 25'(ry_ff) - 25'(rd_y);
         S_C_MY: hold_ff <= mul_ff;
         S_C_CMP: begin
            if (idx_ff == '0 || sum50 < best_ff) begin
               best_ff    <= sum50;
               closest_ff <= idx_ff;
            end
            if (!last_pt) idx_ff <= idx_ff + AW'(1);
         end
         S_GOAL: cmd_ff <= '{status: ST_GOAL, linear_speed: '0, angular_speed: '0};
         S_LA: begin
            l_ff   <= (la_clip < signed'(70'(min_la_ff))) ? min_la_ff : la_clip[22:0];
            idx_ff <= closest_ff;
            acc_ff <= '0;
         end
         S_W_LD0: begin
            x0_ff <= rd_x;
            y0_ff <= rd_y;
            px_ff <= rd_x;
            py_ff <= rd_y;
         end
         S_W_LD1: begin
            x1_ff <= rd_x;
            y1_ff <= rd_y;
            dy_ff <= wdy;
         end
         S_W_MY: hold_ff <= mul_ff;
         S_W_SUM: begin
            sq_val_ff  <= sum50;
            sq_rem_ff  <= '0;
            sq_root_ff <= '0;
            sq_cnt_ff  <= 5'd24;
         end
         S_W_SQ: begin
            sq_val_ff <= {sq_val_ff[47:0], 2'b00};
            if (sq_rem_t >= 28'(sq_trial)) begin
               sq_rem_ff  <= sq_rem_t - 28'(sq_trial);
               sq_root_ff <= {sq_root_ff[23:0], 1'b1};
            end else begin
               sq_rem_ff  <= sq_rem_t;
               sq_root_ff <= {sq_root_ff[23:0], 1'b0};
            end
            sq_cnt_ff <= sq_cnt_ff - 5'd1;
         end
         S_W_ACC: begin
            if (acc_new >= 27'(l_ff)) begin
               px_ff <= x1_ff;
               py_ff <= y1_ff;
            end else begin
               acc_ff <= acc_new;
               x0_ff  <= x1_ff;
               y0_ff  <= y1_ff;
               px_ff  <= x1_ff;
               py_ff  <= y1_ff;
               idx_ff <= idx_ff + AW'(1);
            end
         end
         S_I_Y0: hold_ff <= mul_ff;
         S_I_XD: if (!dv_busy_ff) px_ff <= ix_new[23:0];
         S_I_YD: if (!dv_busy_ff) py_ff <= iy_new[23:0];
         S_ROT: begin
            cx_ff    <= CORDIC_GAIN;
            cy_ff    <= '0;
            citer_ff <= '0;
            if (17'(signed'(heading_ff)) > 17'sd16384) begin
               cz_ff   <= 17'(signed'(heading_ff)) - 17'sd32768;
               cneg_ff <= 1'b1;
            end else if (17'(signed'(heading_ff)) < -17'sd16384) begin
               cz_ff   <= 17'(signed'(heading_ff)) + 17'sd32768;
               cneg_ff <= 1'b1;
            end else begin
               cz_ff   <= 17'(signed'(heading_ff));
               cneg_ff <= 1'b0;
            end
         end
         S_R_IT: begin
            if (!cz_ff[16]) begin
               cx_ff <= cx_ff - sh_y;
               cy_ff <= cy_ff + sh_x;
               cz_ff <= cz_ff - atan_v;
            end else begin
               cx_ff <= cx_ff + sh_y;
               cy_ff <= cy_ff - sh_x;
               cz_ff <= cz_ff + atan_v;
            end
            citer_ff <= citer_ff + 4'd1;
         end
         S_R_M2: hold_ff <= mul_ff;
         S_R_Y: yr_ff <= yr_full[27:0];
         S_K_DIV: if (l_ff == '0) kappa_ff <= '0;
         S_K_WAIT: begin
            if (!dv_busy_ff)
               kappa_ff <= dv_neg_ff ? -42'(ksat) : 42'(ksat);
         end
         S_S_CMP: v_ff <= vmax_ff;
         S_S_WAIT: begin
            if (!dv_busy_ff && dv_quo_ff < 64'(vmax_ff)) v_ff <= dv_quo_ff[14:0];
         end
         S_O_CLAMP: begin
            cmd_ff <= '{status: ST_TRACKING, linear_speed: 16'(v_ff),
                        angular_speed: om_clip};
         end
         default: ;
      endcase
   end

   // Radix-2 restoring divider, one quotient bit per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_busy_ff <= 1'b0;
      end else if (div_start) begin
         dv_rem_ff  <= '0;
         dv_quo_ff  <= div_num;
         dv_den_ff  <= div_den;
         dv_neg_ff  <= div_neg;
         dv_cnt_ff  <= 7'd64;
         dv_busy_ff <= 1'b1;
      end else if (dv_busy_ff) begin
         dv_rem_ff <= dv_ge ? (dv_sh - {1'b0, dv_den_ff}) : dv_sh;
         dv_quo_ff <= {dv_quo_ff[62:0], dv_ge};
         dv_cnt_ff <= dv_cnt_ff - 7'd1;
         if (dv_cnt_ff == 7'd1) dv_busy_ff <= 1'b0;
      end
   end

   // Result register: the finished command moves in only once the slot is free.
   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff <= cmd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_FINISH && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("path point count exceeds table depth");

   // The divider is only started when it is free.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !dv_busy_ff)
      else $error("divider started while busy");

   // A result other than tracking carries zero speeds.
   a_zero_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_TRACKING) |->
      (rsp_ff.linear_speed == '0 && rsp_ff.angular_speed == '0))
      else $error("stop result with nonzero command");

   // A query transaction leaves the idle state at once.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.req_type) |=> !req_ready)
      else $error("block ready again right after a query");

endmodule

[tb/pure_pursuit_path_tracker_checker.sv]
// Checker for the pure pursuit path tracker: mirrors the path table and registers, predicts each command.
`timescale 1ns / 1ps

module pure_pursuit_path_tracker_checker
   import ppt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  ppt_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  ppt_rsp_type rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          pending_commands,
   output int          failures
);

   longint        path_x [PPT_MAX_POINTS];
   longint        path_y [PPT_MAX_POINTS];
   int            stored_points;
   logic          cfg_enable;
   logic [15:0]   cfg_la_time;
   logic [22:0]   cfg_min_la;
   logic [22:0]   cfg_max_la;
   logic [14:0]   cfg_speed_lim;
   logic [14:0]   cfg_turn_lim;
   logic [22:0]   cfg_radius;
   ppt_rsp_type   expected_commands[$];

   assign pending_commands = expected_commands.size();

   function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
      return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
   endfunction

   function automatic longint floor_sqrt(longint value);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = value;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   // Sine and cosine of the heading in Q2.30, folded into the right half plane first.
   function automatic void heading_sincos(logic [15:0] heading, output longint s,
                                          output longint c);
      int     a;
      int     z;
      bit     flip;
      longint x;
      longint y;
      longint nx;
      a = heading;
      flip = 0;
      x = CORDIC_GAIN;
      y = 0;
      if (a >= 32768) a -= 65536;
      if (a > 16384) begin
         a -= 32768;
         flip = 1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1;
      end
      z = a;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= cordic_atan(i[3:0]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += cordic_atan(i[3:0]);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic ppt_rsp_type steer_command(ppt_req_type q);
      ppt_rsp_type cmd;
      longint      rx, ry, best, d, la, px, py, acc, seg, num, s, c, yr, kappa, v, omega;
      logic [63:0] kabs, prod, vc;
      int          closest;
      bit          found;
      cmd.status = ST_NOT_READY;
      cmd.linear_speed = 0;
      cmd.angular_speed = 0;
      rx = q.pos_x;
      ry = q.pos_y;
      found = 0;
      if (!cfg_enable || stored_points == 0) return cmd;
      closest = 0;
      best = sq_dist(rx, ry, path_x[0], path_y[0]);
      for (int i = 1; i < stored_points; i++) begin
         d = sq_dist(rx, ry, path_x[i], path_y[i]);
         if (d < best) begin
            best = d;
            closest = i;
         end
      end
      if (closest == stored_points - 1 && best <= longint'(GOAL_DIST2_MAX)) begin
         cmd.status = ST_GOAL;
         return cmd;
      end
      la = (longint'(q.current_speed) * longint'(cfg_la_time)) >>> 12;
      if (la > longint'(cfg_max_la)) la = cfg_max_la;
      if (la < longint'(cfg_min_la)) la = cfg_min_la;
      px = path_x[stored_points - 1];
      py = path_y[stored_points - 1];
      acc = 0;
      for (int i = closest; i + 1 < stored_points && !found; i++) begin
         seg = floor_sqrt(sq_dist(path_x[i + 1], path_y[i + 1], path_x[i], path_y[i]));
         acc += seg;
         if (acc >= la) begin
            found = 1;
            if (seg == 0) begin
               px = path_x[i + 1];
               py = path_y[i + 1];
            end else begin
               num = seg - (acc - la);
               px = path_x[i] + ((path_x[i + 1] - path_x[i]) * num) / seg;
               py = path_y[i] + ((path_y[i + 1] - path_y[i]) * num) / seg;
            end
         end
      end
      heading_sincos(q.heading, s, c);
      yr = (c * (py - ry) - s * (px - rx)) >>> 30;
      kappa = 0;
      if (la > 0) begin
         kappa = (yr * (64'sd1 <<< 29)) / (la * la);
         if (kappa > longint'(KAPPA_SAT)) kappa = KAPPA_SAT;
         if (kappa < -longint'(KAPPA_SAT)) kappa = -longint'(KAPPA_SAT);
      end
      v = cfg_speed_lim;
      kabs = (kappa < 0) ? -kappa : kappa;
      prod = kabs * 64'(cfg_radius);
      if (prod > SLOW_THRESHOLD) begin
         vc = (64'(cfg_speed_lim) << 28) / prod;
         if (longint'(vc) < v) v = vc;
      end
      omega = (v * kappa) >>> 16;
      if (omega > longint'(cfg_turn_lim)) omega = cfg_turn_lim;
      if (omega < -longint'(cfg_turn_lim)) omega = -longint'(cfg_turn_lim);
      cmd.status = ST_TRACKING;
      cmd.linear_speed = v[15:0];
      cmd.angular_speed = omega[15:0];
      return cmd;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         stored_points <= 0;
         cfg_enable <= 1'b0;
         cfg_la_time <= 16'd4096;
         cfg_min_la <= 23'd1229;
         cfg_max_la <= 23'd6144;
         cfg_speed_lim <= 15'd2048;
         cfg_turn_lim <= 15'd4096;
         cfg_radius <= 23'd4096;
         failures <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_ENABLE:    cfg_enable <= pwdata[0];
               REG_LA_TIME:   cfg_la_time <= pwdata[15:0];
               REG_MIN_LA:    cfg_min_la <= pwdata[22:0];
               REG_MAX_LA:    cfg_max_la <= pwdata[22:0];
               REG_SPEED_LIM: cfg_speed_lim <= pwdata[14:0];
               REG_TURN_LIM:  cfg_turn_lim <= pwdata[14:0];
               REG_RADIUS:    cfg_radius <= pwdata[22:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (req_data.req_type) begin
               expected_commands.push_back(steer_command(req_data));
            end else begin
               // A restart and the store share this transaction.
               automatic int slot = req_data.first_point ? 0 : stored_points;
               if (slot < PPT_MAX_POINTS) begin
                  path_x[slot] = req_data.pos_x;
                  path_y[slot] = req_data.pos_y;
                  stored_points <= slot + 1;
               end else begin
                  stored_points <= slot;
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_commands.size() == 0) begin
               $error("unexpected command: status %0d", rsp_data.status);
               failures <= failures + 1;
            end else begin
               automatic ppt_rsp_type e = expected_commands.pop_front();
               automatic int bad = 0;
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_data.status);
                  bad++;
               end
               if (rsp_data.linear_speed !== e.linear_speed) begin
                  $error("linear_speed: expected %0d, actual %0d", e.linear_speed,
                         rsp_data.linear_speed);
                  bad++;
               end
               if (rsp_data.angular_speed !== e.angular_speed) begin
                  $error("angular_speed: expected %0d, actual %0d", e.angular_speed,
                         rsp_data.angular_speed);
                  bad++;
               end
               failures <= failures + bad;
            end
         end
      end
   end

endmodule

[tb/pure_pursuit_path_tracker_tb.sv]
// Testbench top for the pure pursuit path tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module pure_pursuit_path_tracker_tb;
   import ppt_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   ppt_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   ppt_rsp_type rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          pending_commands;
   int          failures;
   bit          quiet;
   bit          hold_request;
   int          hold_left;
   longint      wx, wy;

   pure_pursuit_path_tracker DUT (.*);

   pure_pursuit_path_tracker_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("pure_pursuit_path_tracker: mismatch");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ready = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 0;
            hold_left = 3000;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet || ($urandom_range(99) >= 9);
         end
      end
   end

   task automatic send(ppt_req_type it);
      bit taken;
      if (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      forever begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
         if (taken) break;
      end
   endtask

   task automatic load_point(bit restart, longint x, longint y);
      ppt_req_type it;
      it = '0;
      it.first_point = restart;
      it.pos_x = x[23:0];
      it.pos_y = y[23:0];
      send(it);
   endtask

   task automatic query(longint x, longint y, int heading, int speed);
      ppt_req_type it;
      it = '0;
      it.req_type = 1'b1;
      it.pos_x = x[23:0];
      it.pos_y = y[23:0];
      it.heading = heading[15:0];
      it.current_speed = speed[15:0];
      send(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_commands != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, int unsigned value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(int unsigned en, int unsigned t, int unsigned lo, int unsigned hi,
                            int unsigned vmax, int unsigned wmax, int unsigned rad);
      csr_write(REG_ENABLE, en);
      csr_write(REG_LA_TIME, t);
      csr_write(REG_MIN_LA, lo);
      csr_write(REG_MAX_LA, hi);
      csr_write(REG_SPEED_LIM, vmax);
      csr_write(REG_TURN_LIM, wmax);
      csr_write(REG_RADIUS, rad);
   endtask

   function automatic longint rand_span(int unsigned span);
      return longint'($urandom_range(2 * span)) - longint'(span);
   endfunction

   // One well-formed path followed by a few queries near it; now and then random noise.
   task automatic random_burst(ref int items);
      ppt_req_type noise;
      int          n;
      int          k;
      longint      px [16];
      longint      py [16];
      if ($urandom_range(9) == 0) begin
         noise = ppt_req_type'(82'({$urandom, $urandom, $urandom}));
         send(noise);
         items++;
         return;
      end
      n = $urandom_range(1, 8);
      px[0] = rand_span(1 << 21);
      py[0] = rand_span(1 << 21);
      for (int i = 1; i < n; i++) begin
         px[i] = px[i - 1] + ($urandom_range(7) == 0 ? 0 : rand_span(1 << 13));
         py[i] = py[i - 1] + ($urandom_range(7) == 0 ? 0 : rand_span(1 << 13));
      end
      for (int i = 0; i < n; i++) load_point(i == 0, px[i], py[i]);
      items += n;
      repeat ($urandom_range(1, 4)) begin
         k = $urandom_range(n - 1);
         if ($urandom_range(4) == 0)
            query(px[n - 1] + rand_span(300), py[n - 1] + rand_span(300),
                  $urandom_range(65535), $urandom_range(65535));
         else
            query(px[k] + rand_span(1 << 12), py[k] + rand_span(1 << 12),
                  $urandom_range(65535), int'(rand_span(1 << 15)));
         items++;
      end
   endtask

   initial begin
      int items;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      quiet = 0;
      hold_request = 0;
      items = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Disabled, then enabled with an empty table.
      query(0, 0, 0, 4096);
      drain();
      csr_write(REG_ENABLE, 1);
      query(100, -100, 0, 4096);
      // Straight run with a repeated point and a kink at the end.
      load_point(1, 0, 0);
      load_point(0, 4096, 0);
      load_point(0, 8192, 0);
      load_point(0, 8192, 0);
      load_point(0, 12288, 4096);
      // The receiver holds off while these queries keep coming, so the block stalls.
      hold_request = 1;
      query(12288, 4096, 0, 4096);
      query(12288 + 300, 4096 - 300, 16384, 0);
      query(2048, 0, 0, 4096);
      query(0, 1000, 16384, 32767);
      query(0, -1000, 32768, -32768);
      query(8388607, 8388607, 49152, 1000);
      query(-8388608, -8388608, 65535, -1);
      query(6144, 100, 8192, 20000);
      query(8191, 50, 0, 2000);
      drain();

      // Full table: extra loads are ignored.
      quiet = 1;
      for (int i = 0; i < PPT_MAX_POINTS + 4; i++) load_point(i == 0, i * 512, (i % 7) * 300);
      query(0, 0, 0, 8192);
      query(300000, 0, 0, 4096);
      drain();
      quiet = 0;

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: configure(1, 4096, 1229, 6144, 2048, 4096, 4096);
            1: configure(1, 65535, 0, 8388607, 32767, 32767, 8388607);
            2: configure(1, 0, 8388607, 0, 0, 0, 1);
            3: configure(1, 12000, 2000, 30000, 20000, 1000, 0);
            default: configure(1, $urandom_range(65535), $urandom_range(20000),
                               $urandom_range(60000), $urandom_range(32767),
                               $urandom_range(32767), $urandom_range(1, 8388607));
         endcase
         quiet = (phase == 1);
         do random_burst(items); while (items < 6 * (phase + 1));
         drain();
      end
      quiet = 0;
      csr_write(REG_ENABLE, 0);
      query(0, 0, 0, 4096);
      drain();

      repeat (50) @(posedge clock);
      if (failures == 0)
         $display("pure_pursuit_path_tracker: match");
      else
         $display("pure_pursuit_path_tracker: mismatch");
      $finish;
   end

endmodule
